/* hdl/mlfo_pkg.sv */
`default_nettype none

package mlfo_pkg;

    // width of the channel field of an item
    localparam int CHAN_W = 5;

    // depth is clamped to this many percent on a settings write
    localparam logic [6:0] DEPTH_MAX = 7'd100;

    // queue between front and back, and the result queue
    localparam int CMD_QDEPTH = 2;
    localparam int OUT_QDEPTH = 8;

    // coefficient numerators: 32768*200 + 100 and 16384*200 + 100
    localparam logic [22:0] AMP_BIAS = 23'd6553700;
    localparam logic signed [23:0] PAN_BIAS = 24'sd3276900;

    // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT for y < 2^20
    localparam logic [20:0] DIV25_MUL = 21'd1342178;
    localparam int DIV25_SHIFT = 25;

    // pi/2 in Q30 and the Taylor divisors (2k)(2k+1)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef enum logic {
        CLS_TICK,
        CLS_WRITE
    } t_cls;

    typedef enum logic [2:0] {
        WAVE_SINE,
        WAVE_TRIANGLE,
        WAVE_SAW_UP,
        WAVE_SAW_DOWN,
        WAVE_SQUARE,
        WAVE_RANDOM
    } t_wave;

    typedef struct packed {
        logic              action;
        logic [4:0]        channel;
        logic              enabled;
        logic [2:0]        waveform;
        logic [6:0]        depth_pct;
        logic [23:0]       phase_step;
        logic [3:0]        targets;
        logic signed [15:0] random_sample;
    } t_in_item;

    typedef struct packed {
        logic [4:0]        out_channel;
        logic signed [15:0] lfo_value;
        logic [15:0]       amp_coef;
        logic [15:0]       pan_coef;
        logic [3:0]        target_mask;
        logic              wrapped;
    } t_out_item;

    // stored per-channel settings, 39 bits
    typedef struct packed {
        logic [3:0]  targets;
        logic [23:0] step;
        logic [6:0]  depth;
        t_wave       wave;
        logic        enabled;
    } t_settings;

    // classified item waiting for the back end
    typedef struct packed {
        t_cls              cls;
        logic [4:0]        channel;
        t_settings         settings;
        logic signed [15:0] random_sample;
    } t_cmd;

    // tick in flight through the waveform pipeline
    typedef struct packed {
        logic [4:0]        channel;
        t_wave             wave;
        logic [6:0]        depth;
        logic [3:0]        targets;
        logic              wrapped;
        logic signed [15:0] held;
    } t_tick;

    // quarter-wave sine entry in Q15, Taylor series in Q30
    function automatic logic [15:0] sine_entry(input int unsigned idx,
                                               input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] mag;
        logic [63:0] q15;
        longint      sum;
        x = (HALF_PI_Q30 * 64'(idx)) >> tbits;
        mag = x;
        sum = longint'(x);
        for (int k = 0; k < 6; k++) begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = mag / SINE_DIV[k];
            if (k % 2 == 0) begin
                sum = sum - longint'(mag);
            end else begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q15 = (64'(sum) * 64'd32768 + 64'd536870912) >> 30;
        if (q15 > 64'd32767) begin
            q15 = 64'd32767;
        end
        return q15[15:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/multichannel_lfo_generator.sv */
// a productive tick passes the front queue, the state stage, waveform stages b to d and the result queue
// throughput: one item per cycle, settings writes and ticks alike, while the credit check finds room; the
//   per-channel phase read-modify-write completes within the state stage
// a settings write or an idle tick produces no item and leaves one bubble in the pipe
// reset (synchronous, active low): all phases, held samples and settings clear,
//   every channel disabled, both queues empty; no sweep, items are taken right away
`default_nettype none

module multichannel_lfo_generator #(
    parameter int CHANNELS        = 32,
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // item side
    input  wire                  push,
    output logic                 full,
    input  mlfo_pkg::t_in_item   i_item,
    // result side
    output logic                 empty,
    input  wire                  pop,
    output mlfo_pkg::t_out_item  o_item
);

    // only channels reachable through the 5-bit channel field get storage
    localparam int SLOTS = (CHANNELS < (1 << mlfo_pkg::CHAN_W)) ?
                           CHANNELS : (1 << mlfo_pkg::CHAN_W);
    localparam int OCW   = $clog2(mlfo_pkg::OUT_QDEPTH + 1);

    // front end: accept, drop out-of-range channels, clamp depth, queue
    logic                  w_cmd_valid;
    mlfo_pkg::t_cmd        w_cmd;
    logic                  w_issue;

    mlfo_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (w_issue),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd)
    );

    // back end, first stage: settings store and phase accumulators
    logic                  w_tick_valid;
    mlfo_pkg::t_tick       w_tick;
    logic [PHASE_BITS-1:0] w_phase;

    mlfo_state #(
        .SLOTS      (SLOTS),
        .PHASE_BITS (PHASE_BITS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_issue),
        .i_cmd   (w_cmd),
        .o_valid (w_tick_valid),
        .o_tick  (w_tick),
        .o_phase (w_phase)
    );

    // back end, waveform and coefficient pipeline
    logic                  w_res_valid;
    mlfo_pkg::t_out_item   w_res;
    logic [1:0]            w_busy;

    mlfo_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_wave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tick_valid),
        .i_tick  (w_tick),
        .i_phase (w_phase),
        .o_valid (w_res_valid),
        .o_res   (w_res),
        .o_busy  (w_busy)
    );

    // result queue
    logic [OCW-1:0]        w_out_count;

    mlfo_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_item  (w_res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_item),
        .o_count (w_out_count)
    );

    // credit check: a new command only leaves the front queue when the result
    // queue can hold everything already in the pipe plus one more, so a
    // stalled consumer never overruns the pipeline
    logic [2:0]            w_inflight;
    logic                  w_room;

    assign w_inflight = 3'(w_tick_valid) + 3'(w_busy);
    assign w_room = (5'(w_out_count) + 5'(w_inflight)) < 5'(mlfo_pkg::OUT_QDEPTH);
    assign w_issue = w_cmd_valid && w_room;

endmodule

`default_nettype wire

/* hdl/mlfo_front.sv */
`default_nettype none

module mlfo_front #(
    parameter int CHANNELS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  mlfo_pkg::t_in_item   i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output mlfo_pkg::t_cmd       o_cmd
);

    localparam int QPW = $clog2(mlfo_pkg::CMD_QDEPTH);
    localparam int QCW = $clog2(mlfo_pkg::CMD_QDEPTH + 1);

    mlfo_pkg::t_cmd r_q [mlfo_pkg::CMD_QDEPTH];
    logic [QPW-1:0] r_wptr, n_wptr;
    logic [QPW-1:0] r_rptr, n_rptr;
    logic [QCW-1:0] r_cnt, n_cnt;

    logic           w_in_range;
    logic           w_take;
    logic           w_pop;
    mlfo_pkg::t_cmd w_cmd;

    // out-of-range channels are accepted and dropped here
    assign w_in_range = 9'(i_item.channel) < 9'(CHANNELS);
    assign w_take = i_push && !o_full && w_in_range;
    assign w_pop = i_pop && o_valid;

    always_comb begin
        w_cmd.cls = i_item.action ? mlfo_pkg::CLS_WRITE : mlfo_pkg::CLS_TICK;
        w_cmd.channel = i_item.channel;
        w_cmd.settings.enabled = i_item.enabled;
        w_cmd.settings.wave = mlfo_pkg::t_wave'(i_item.waveform);
        w_cmd.settings.depth = (i_item.depth_pct > mlfo_pkg::DEPTH_MAX) ?
                               mlfo_pkg::DEPTH_MAX : i_item.depth_pct;
        w_cmd.settings.step = i_item.phase_step;
        w_cmd.settings.targets = i_item.targets;
        w_cmd.random_sample = i_item.random_sample;
    end

    always_comb begin
        n_wptr = w_take ? r_wptr + QPW'(1) : r_wptr;
        n_rptr = w_pop ? r_rptr + QPW'(1) : r_rptr;
        n_cnt = r_cnt + QCW'(w_take) - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    assign o_full = (r_cnt == QCW'(mlfo_pkg::CMD_QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rptr];

endmodule

`default_nettype wire

/* hdl/mlfo_state.sv */
`default_nettype none

module mlfo_state #(
    parameter int SLOTS      = 32,
    parameter int PHASE_BITS = 24
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  mlfo_pkg::t_cmd        i_cmd,
    output logic                  o_valid,
    output mlfo_pkg::t_tick       o_tick,
    output logic [PHASE_BITS-1:0] o_phase
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int STEP_W = (PHASE_BITS < 24) ? PHASE_BITS : 24;

    logic [PHASE_BITS-1:0] r_phase [SLOTS];
    logic signed [15:0]    r_held  [SLOTS];
    mlfo_pkg::t_settings   r_set   [SLOTS];

    logic                  r_valid;
    mlfo_pkg::t_tick       r_tick;
    logic [PHASE_BITS-1:0] r_phase_out;

    logic [IDX_W-1:0]      w_idx;
    mlfo_pkg::t_settings   w_set;
    logic [PHASE_BITS-1:0] w_step;
    logic [PHASE_BITS:0]   w_sum;
    logic                  w_wrap;
    logic                  w_live;
    logic                  w_write;
    logic signed [15:0]    w_held;

    assign w_idx = i_cmd.channel[IDX_W-1:0];
    assign w_set = r_set[w_idx];
    assign w_step = PHASE_BITS'(w_set.step[STEP_W-1:0]);
    assign w_write = i_valid && (i_cmd.cls == mlfo_pkg::CLS_WRITE);
    assign w_live = i_valid && (i_cmd.cls == mlfo_pkg::CLS_TICK) &&
                    w_set.enabled && (w_step != '0);

    assign w_sum = {1'b0, r_phase[w_idx]} + {1'b0, w_step};
    assign w_wrap = w_sum[PHASE_BITS];
    assign w_held = (w_wrap && (w_set.wave == mlfo_pkg::WAVE_RANDOM)) ?
                    i_cmd.random_sample : r_held[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_phase[i] <= '0;
                r_held[i] <= '0;
                r_set[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            if (w_write) begin
                r_set[w_idx] <= i_cmd.settings;
            end
            if (w_live) begin
                r_phase[w_idx] <= w_sum[PHASE_BITS-1:0];
                r_held[w_idx] <= w_held;
            end
            r_valid <= w_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick.channel <= i_cmd.channel;
        r_tick.wave <= w_set.wave;
        r_tick.depth <= w_set.depth;
        r_tick.targets <= w_set.targets;
        r_tick.wrapped <= w_wrap;
        r_tick.held <= w_held;
        r_phase_out <= w_sum[PHASE_BITS-1:0];
    end

    assign o_valid = r_valid;
    assign o_tick = r_tick;
    assign o_phase = r_phase_out;

endmodule

`default_nettype wire

/* hdl/mlfo_wave.sv */
`default_nettype none

module mlfo_wave #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  mlfo_pkg::t_tick       i_tick,
    input  wire [PHASE_BITS-1:0]  i_phase,
    output logic                  o_valid,
    output mlfo_pkg::t_out_item   o_res,
    output logic [1:0]            o_busy
);

    localparam int STB  = SINE_TABLE_BITS;
    localparam int QLEN = 1 << STB;
    localparam int IW   = STB + 1;
    localparam int QW   = PHASE_BITS + STB + 2;
    localparam int TW   = PHASE_BITS + 17;
    localparam int SW   = PHASE_BITS + 16;

    // quarter-wave table, built at elaboration
    logic [15:0] w_rom [QLEN+1];
    for (genvar gi = 0; gi <= QLEN; gi++) begin : g_rom
        localparam logic [15:0] ENTRY = mlfo_pkg::sine_entry(gi, SINE_TABLE_BITS);
        assign w_rom[gi] = ENTRY;
    end

    // stage b: table read and the other waveforms
    logic [QW-1:0]      w_qwide;
    logic [STB+1:0]     w_q;
    logic [1:0]         w_quad;
    logic [IW-1:0]      w_idx;
    logic [TW-1:0]      w_t17wide;
    logic [SW-1:0]      w_t16wide;
    logic [15:0]        w_u17;
    logic [15:0]        w_t16;
    logic               w_half;
    logic [15:0]        w_other;

    assign w_qwide = {i_phase, {(STB+2){1'b0}}} >> PHASE_BITS;
    assign w_q = w_qwide[STB+1:0];
    assign w_quad = w_q[STB+1:STB];
    assign w_idx = w_quad[0] ? IW'(QLEN) - {1'b0, w_q[STB-1:0]} : {1'b0, w_q[STB-1:0]};

    assign w_t17wide = {i_phase, 17'd0} >> PHASE_BITS;
    assign w_t16wide = {i_phase, 16'd0} >> PHASE_BITS;
    assign w_u17 = w_t17wide[15:0];
    assign w_t16 = w_t16wide[15:0];
    assign w_half = i_phase[PHASE_BITS-1];

    always_comb begin
        unique case (i_tick.wave)
            mlfo_pkg::WAVE_TRIANGLE: begin
                if (w_half) begin
                    w_other = (w_u17 == '0) ? 16'h7FFF : 16'h8000 - w_u17;
                end else begin
                    w_other = w_u17 ^ 16'h8000;
                end
            end
            mlfo_pkg::WAVE_SAW_UP:   w_other = w_t16 ^ 16'h8000;
            mlfo_pkg::WAVE_SAW_DOWN: w_other = (w_t16 == '0) ? 16'h7FFF : 16'h8000 - w_t16;
            mlfo_pkg::WAVE_SQUARE:   w_other = w_half ? 16'h8000 : 16'h7FFF;
            mlfo_pkg::WAVE_RANDOM:   w_other = i_tick.held;
            default:                 w_other = '0;
        endcase
    end

    logic               r_b_valid;
    mlfo_pkg::t_tick    r_b_tick;
    logic [15:0]        r_b_mag;
    logic               r_b_neg;
    logic               r_b_sine;
    logic [15:0]        r_b_other;

    always_ff @(posedge i_clk) begin
        r_b_tick <= i_tick;
        r_b_mag <= w_rom[w_idx];
        r_b_neg <= w_quad[1];
        r_b_sine <= (i_tick.wave == mlfo_pkg::WAVE_SINE);
        r_b_other <= w_other;
    end

    // stage c: final value
    logic               r_c_valid;
    mlfo_pkg::t_tick    r_c_tick;
    logic signed [15:0] r_c_v;
    logic [15:0]        w_sine;

    assign w_sine = r_b_neg ? (~r_b_mag + 16'd1) : r_b_mag;

    always_ff @(posedge i_clk) begin
        r_c_tick <= r_b_tick;
        r_c_v <= r_b_sine ? w_sine : r_b_other;
    end

    // stage d: coefficient numerators
    logic [16:0]        w_span;
    logic [17:0]        w_span_wide;
    logic [23:0]        w_amp_mul;
    logic signed [23:0] w_pan_mul;
    logic signed [23:0] w_pan_sum;

    assign w_span_wide = 18'sd32768 - {{2{r_c_v[15]}}, r_c_v};
    assign w_span = w_span_wide[16:0];
    assign w_amp_mul = 24'(r_c_tick.depth) * 24'(w_span);
    assign w_pan_mul = $signed({17'd0, r_c_tick.depth}) * $signed({{8{r_c_v[15]}}, r_c_v});
    assign w_pan_sum = mlfo_pkg::PAN_BIAS + w_pan_mul;

    logic               r_d_valid;
    mlfo_pkg::t_tick    r_d_tick;
    logic signed [15:0] r_d_v;
    logic [22:0]        r_d_amp_num;
    logic [22:0]        r_d_pan_num;

    always_ff @(posedge i_clk) begin
        r_d_tick <= r_c_tick;
        r_d_v <= r_c_v;
        r_d_amp_num <= mlfo_pkg::AMP_BIAS - w_amp_mul[22:0];
        r_d_pan_num <= w_pan_sum[22:0];
    end

    // divide by 200: drop three bits, then multiply by the reciprocal of 25
    logic [40:0] w_amp_prod;
    logic [40:0] w_pan_prod;

    assign w_amp_prod = 41'(r_d_amp_num[22:3]) * 41'(mlfo_pkg::DIV25_MUL);
    assign w_pan_prod = 41'(r_d_pan_num[22:3]) * 41'(mlfo_pkg::DIV25_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_comb begin
        o_res.out_channel = r_d_tick.channel;
        o_res.lfo_value = r_d_v;
        o_res.amp_coef = w_amp_prod[mlfo_pkg::DIV25_SHIFT +: 16];
        o_res.pan_coef = w_pan_prod[mlfo_pkg::DIV25_SHIFT +: 16];
        o_res.target_mask = r_d_tick.targets;
        o_res.wrapped = r_d_tick.wrapped;
    end

    assign o_valid = r_d_valid;
    assign o_busy = 2'(r_b_valid) + 2'(r_c_valid) + 2'(r_d_valid);

endmodule

`default_nettype wire

/* hdl/mlfo_outq.sv */
`default_nettype none

module mlfo_outq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  mlfo_pkg::t_out_item   i_item,
    output logic                  o_empty,
    input  wire                   i_pop,
    output mlfo_pkg::t_out_item   o_item,
    output logic [$clog2(mlfo_pkg::OUT_QDEPTH+1)-1:0] o_count
);

    localparam int QPW = $clog2(mlfo_pkg::OUT_QDEPTH);
    localparam int QCW = $clog2(mlfo_pkg::OUT_QDEPTH + 1);

    mlfo_pkg::t_out_item r_q [mlfo_pkg::OUT_QDEPTH];
    logic [QPW-1:0] r_wptr, n_wptr;
    logic [QPW-1:0] r_rptr, n_rptr;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           w_pop;

    assign w_pop = i_pop && !o_empty;

    always_comb begin
        n_wptr = i_push ? r_wptr + QPW'(1) : r_wptr;
        n_rptr = w_pop ? r_rptr + QPW'(1) : r_rptr;
        n_cnt = r_cnt + QCW'(i_push) - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_item;
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_item = r_q[r_rptr];
    assign o_count = r_cnt;

endmodule

`default_nettype wire
